// ===== hdl/ldpm_pkg.sv =====
// Shared types, constants and arithmetic helpers of the lens distortion point map.
`default_nettype none

package ldpm_pkg;

  localparam int FRAC      = 24;
  localparam int MUL_LAT   = 5;
  localparam int DIV_STEPS = 57;
  localparam int DIV_LAT   = DIV_STEPS + 1;

  localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SAT_MIN = -SAT_MAX;
  localparam logic signed [64:0] SUM_MAX = 65'(SAT_MAX);
  localparam logic signed [64:0] SUM_MIN = -SUM_MAX;
  localparam logic signed [63:0] ONE_Q24 = 64'sd1 <<< FRAC;

  typedef logic signed [63:0] fix_t;

  typedef enum logic [2:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_RADIAL_1 = 3'd4,
    REG_RADIAL_2 = 3'd5,
    REG_TANGENT_1 = 3'd6,
    REG_TANGENT_2 = 3'd7
  } cfg_idx_e;

  function automatic fix_t sadd(input fix_t a, input fix_t b);
    logic signed [64:0] s;
    begin
      s = $signed({a[63], a}) + $signed({b[63], b});
      if (s > SUM_MAX) begin
        sadd = SAT_MAX;
      end else if (s < SUM_MIN) begin
        sadd = SAT_MIN;
      end else begin
        sadd = s[63:0];
      end
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ldpm_if.sv =====
// Handshake channels for ideal input points and distorted output points.
`default_nettype none

interface ldpm_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] ideal_x;
  logic signed [31:0] ideal_y;

  modport source(output valid, output ideal_x, output ideal_y, input ready);
  modport sink(input valid, input ideal_x, input ideal_y, output ready);
endinterface

interface ldpm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] warped_x;
  logic signed [31:0] warped_y;
  logic               clipped;

  modport source(output valid, output warped_x, output warped_y, output clipped,
                 input ready);
  modport sink(input valid, input warped_x, input warped_y, input clipped,
               output ready);
endinterface

`default_nettype wire

// ===== hdl/ldpm_smul.sv =====
// Pipelined Q.24 multiplier with round half away from zero and saturation.
`default_nettype none

module ldpm_smul import ldpm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic en_i,
  input  wire fix_t a_i,
  input  wire fix_t b_i,
  output fix_t      p_o
);

  localparam logic [127:0] HALF_LSB = 128'd1 << (FRAC - 1);

  logic          neg1_q, neg2_q, neg3_q, neg4_q;
  logic [63:0]   ma_q, mb_q;
  logic [63:0]   ll_q, lh_q, hl_q, hh_q;
  logic [127:0]  prod_q;
  logic [127:0]  rnd;
  logic [62:0]   mag_d, mag_q;
  fix_t          p_q;

  always_comb begin
    rnd = prod_q + HALF_LSB;
    if (|rnd[127:87]) begin
      mag_d = SAT_MAX[62:0];
    end else begin
      mag_d = rnd[86:24];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= a_i[63] ^ b_i[63];
      ma_q   <= a_i[63] ? 64'(-a_i) : 64'(a_i);
      mb_q   <= b_i[63] ? 64'(-b_i) : 64'(b_i);
      neg2_q <= neg1_q;
      ll_q   <= ma_q[31:0] * mb_q[31:0];
      lh_q   <= ma_q[31:0] * mb_q[63:32];
      hl_q   <= ma_q[63:32] * mb_q[31:0];
      hh_q   <= ma_q[63:32] * mb_q[63:32];
      neg3_q <= neg2_q;
      prod_q <= {64'd0, ll_q} + {32'd0, lh_q, 32'd0} + {32'd0, hl_q, 32'd0} + {hh_q, 64'd0};
      neg4_q <= neg3_q;
      mag_q  <= mag_d;
      p_q    <= neg4_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ===== hdl/ldpm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sign applied last.
`default_nettype none

module ldpm_div import ldpm_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   en_i,
  input  wire logic [DIV_STEPS-1:0]   num_i,
  input  wire logic [31:0]            den_i,
  input  wire logic                   neg_i,
  output fix_t                        quo_o
);

  logic [31:0]          rem_q [DIV_STEPS];
  logic [DIV_STEPS-1:0] acc_q [DIV_STEPS];
  logic                 neg_q [DIV_STEPS];
  logic [31:0]          rem_d [DIV_STEPS];
  logic [DIV_STEPS-1:0] acc_d [DIV_STEPS];
  logic [31:0]          rem_in [DIV_STEPS];
  logic [DIV_STEPS-1:0] acc_in [DIV_STEPS];
  logic [32:0]          trial [DIV_STEPS];
  logic                 ge [DIV_STEPS];
  fix_t                 quo_q;

  always_comb begin
    for (int s = 0; s < DIV_STEPS; s++) begin
      rem_in[s] = (s == 0) ? 32'd0 : rem_q[(s == 0) ? 0 : s - 1];
      acc_in[s] = (s == 0) ? num_i : acc_q[(s == 0) ? 0 : s - 1];
      trial[s]  = {rem_in[s], acc_in[s][DIV_STEPS-1]};
      ge[s]     = trial[s] >= {1'b0, den_i};
      rem_d[s]  = ge[s] ? 32'(trial[s] - {1'b0, den_i}) : trial[s][31:0];
      acc_d[s]  = {acc_in[s][DIV_STEPS-2:0], ge[s]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < DIV_STEPS; s++) begin
        rem_q[s] <= rem_d[s];
        acc_q[s] <= acc_d[s];
        neg_q[s] <= (s == 0) ? neg_i : neg_q[(s == 0) ? 0 : s - 1];
      end
      quo_q <= neg_q[DIV_STEPS-1] ? -$signed(64'(acc_q[DIV_STEPS-1]))
                                  : $signed(64'(acc_q[DIV_STEPS-1]));
    end
  end

  assign quo_o = quo_q;

endmodule

`default_nettype wire

// ===== hdl/lens_distortion_point_map.sv =====
// Top level of the Brown-Conrady lens distortion point map.
//
//   channel    direction  payload                          handshake
//   point_i    in         ideal_x, ideal_y (Q16.16)        valid/ready
//   warped_o   out        warped_x, warped_y, clipped      valid/ready
//   cfg        in         cfg_idx_i, cfg_data_i            cfg_we_i, no wait
//
// One item enters per cycle while the output is not stalled.
// The latency is set by the 57-step pipelined divider and six levels of
// five-stage multipliers in the dependency chain of the polynomial.
// Reset clears the valid bits and loads the register defaults.
// A stalled output freezes the whole pipeline, so no item is lost or repeated.
`default_nettype none

module lens_distortion_point_map import ldpm_pkg::*; #(
  parameter int RADIAL_THIRD = 0
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  ldpm_in_if.sink          point_i,
  ldpm_out_if.source       warped_o
);

  localparam int M        = MUL_LAT;
  localparam int PIPE_LAT = DIV_LAT + 6 * M + 5;
  localparam int DLY_R2   = M;
  localparam int DLY_RAD  = M - 1;
  localparam int DLY_XY   = 4 * M + 2;
  localparam int DLY_T    = 3 * M - 1;
  localparam fix_t K3     = 64'(RADIAL_THIRD);
  localparam logic signed [64:0] OUT_MAX65 = 65'sd2147483647;
  localparam logic signed [64:0] OUT_MIN65 = -65'sd2147483648;
  localparam logic signed [31:0] OUT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] OUT_MIN = 32'sh8000_0000;

  logic [31:0]        focal_x_q, focal_y_q;
  logic signed [31:0] center_x_q, center_y_q;
  logic signed [31:0] k1_q, k2_q, p1_q, p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= 32'd65536000;
      focal_y_q  <= 32'd65536000;
      center_x_q <= '0;
      center_y_q <= '0;
      k1_q       <= '0;
      k2_q       <= '0;
      p1_q       <= '0;
      p2_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_FOCAL_X:   focal_x_q  <= cfg_data_i;
        REG_FOCAL_Y:   focal_y_q  <= cfg_data_i;
        REG_CENTER_X:  center_x_q <= cfg_data_i;
        REG_CENTER_Y:  center_y_q <= cfg_data_i;
        REG_RADIAL_1:  k1_q       <= cfg_data_i;
        REG_RADIAL_2:  k2_q       <= cfg_data_i;
        REG_TANGENT_1: p1_q       <= cfg_data_i;
        REG_TANGENT_2: p2_q       <= cfg_data_i;
      endcase
    end
  end

  logic [31:0] fx_eff, fy_eff;
  fix_t        fx64, fy64, k1_64, k2_64, p1_64, p2_64;

  assign fx_eff = (focal_x_q == 32'd0) ? 32'd1 : focal_x_q;
  assign fy_eff = (focal_y_q == 32'd0) ? 32'd1 : focal_y_q;
  assign fx64   = $signed({32'd0, fx_eff});
  assign fy64   = $signed({32'd0, fy_eff});
  assign k1_64  = 64'(k1_q);
  assign k2_64  = 64'(k2_q);
  assign p1_64  = 64'(p1_q);
  assign p2_64  = 64'(p2_q);

  logic                adv;
  logic [PIPE_LAT-1:0] valid_q;

  assign adv           = !valid_q[PIPE_LAT-1] || warped_o.ready;
  assign point_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[PIPE_LAT-2:0], point_i.valid};
    end
  end

  // Offset from the principal point and numerator of the normalizing division.
  logic signed [32:0]   dx, dy;
  logic [32:0]          mx, my;
  logic [DIV_STEPS-1:0] numx_q, numy_q;
  logic                 negx_q, negy_q;

  always_comb begin
    dx = $signed({point_i.ideal_x[31], point_i.ideal_x}) - $signed({center_x_q[31], center_x_q});
    dy = $signed({point_i.ideal_y[31], point_i.ideal_y}) - $signed({center_y_q[31], center_y_q});
    mx = dx[32] ? 33'(-dx) : 33'(dx);
    my = dy[32] ? 33'(-dy) : 33'(dy);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      numx_q <= {mx, 24'd0} + DIV_STEPS'(fx_eff >> 1);
      numy_q <= {my, 24'd0} + DIV_STEPS'(fy_eff >> 1);
      negx_q <= dx[32];
      negy_q <= dy[32];
    end
  end

  fix_t nx, ny;

  ldpm_div u_div_x (.clk_i, .en_i(adv), .num_i(numx_q), .den_i(fx_eff), .neg_i(negx_q),
                    .quo_o(nx));
  ldpm_div u_div_y (.clk_i, .en_i(adv), .num_i(numy_q), .den_i(fy_eff), .neg_i(negy_q),
                    .quo_o(ny));

  fix_t x2, y2, xy;

  ldpm_smul u_mul_x2 (.clk_i, .en_i(adv), .a_i(nx), .b_i(nx), .p_o(x2));
  ldpm_smul u_mul_y2 (.clk_i, .en_i(adv), .a_i(ny), .b_i(ny), .p_o(y2));
  ldpm_smul u_mul_xy (.clk_i, .en_i(adv), .a_i(nx), .b_i(ny), .p_o(xy));

  fix_t r2_q, xy2_q, x2d_q, y2d_q, targx_q, targy_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r2_q    <= sadd(x2, y2);
      xy2_q   <= sadd(xy, xy);
      x2d_q   <= sadd(x2, x2);
      y2d_q   <= sadd(y2, y2);
      targx_q <= sadd(r2_q, x2d_q);
      targy_q <= sadd(r2_q, y2d_q);
    end
  end

  fix_t r4, k1r2, p1xy, p2xy, p2tx, p1ty, r6, k2r4, k3r6;
  fix_t r2_dly_q [DLY_R2];

  ldpm_smul u_mul_r4   (.clk_i, .en_i(adv), .a_i(r2_q), .b_i(r2_q), .p_o(r4));
  ldpm_smul u_mul_k1   (.clk_i, .en_i(adv), .a_i(k1_64), .b_i(r2_q), .p_o(k1r2));
  ldpm_smul u_mul_p1xy (.clk_i, .en_i(adv), .a_i(p1_64), .b_i(xy2_q), .p_o(p1xy));
  ldpm_smul u_mul_p2xy (.clk_i, .en_i(adv), .a_i(p2_64), .b_i(xy2_q), .p_o(p2xy));
  ldpm_smul u_mul_p2tx (.clk_i, .en_i(adv), .a_i(p2_64), .b_i(targx_q), .p_o(p2tx));
  ldpm_smul u_mul_p1ty (.clk_i, .en_i(adv), .a_i(p1_64), .b_i(targy_q), .p_o(p1ty));
  ldpm_smul u_mul_r6   (.clk_i, .en_i(adv), .a_i(r4), .b_i(r2_dly_q[DLY_R2-1]), .p_o(r6));
  ldpm_smul u_mul_k2   (.clk_i, .en_i(adv), .a_i(k2_64), .b_i(r4), .p_o(k2r4));
  ldpm_smul u_mul_k3   (.clk_i, .en_i(adv), .a_i(K3), .b_i(r6), .p_o(k3r6));

  fix_t rad1_q, rad2_q, rad_q, p1xy_dly_q, p2xy_dly_q, tx_q, ty_q;
  fix_t rad1_dly_q [DLY_RAD];
  fix_t rad2_dly_q [DLY_RAD];
  fix_t x_dly_q [DLY_XY];
  fix_t y_dly_q [DLY_XY];
  fix_t tx_dly_q [DLY_T];
  fix_t ty_dly_q [DLY_T];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rad1_q     <= sadd(ONE_Q24, k1r2);
      rad2_q     <= sadd(rad1_dly_q[DLY_RAD-1], k2r4);
      rad_q      <= sadd(rad2_dly_q[DLY_RAD-1], k3r6);
      p1xy_dly_q <= p1xy;
      p2xy_dly_q <= p2xy;
      tx_q       <= sadd(p1xy_dly_q, p2tx);
      ty_q       <= sadd(p1ty, p2xy_dly_q);
      r2_dly_q[0]   <= r2_q;
      rad1_dly_q[0] <= rad1_q;
      rad2_dly_q[0] <= rad2_q;
      x_dly_q[0]    <= nx;
      y_dly_q[0]    <= ny;
      tx_dly_q[0]   <= tx_q;
      ty_dly_q[0]   <= ty_q;
      for (int i = 1; i < DLY_R2; i++) begin
        r2_dly_q[i] <= r2_dly_q[i-1];
      end
      for (int i = 1; i < DLY_RAD; i++) begin
        rad1_dly_q[i] <= rad1_dly_q[i-1];
        rad2_dly_q[i] <= rad2_dly_q[i-1];
      end
      for (int i = 1; i < DLY_XY; i++) begin
        x_dly_q[i] <= x_dly_q[i-1];
        y_dly_q[i] <= y_dly_q[i-1];
      end
      for (int i = 1; i < DLY_T; i++) begin
        tx_dly_q[i] <= tx_dly_q[i-1];
        ty_dly_q[i] <= ty_dly_q[i-1];
      end
    end
  end

  fix_t xr, yr, xd_q, yd_q, mfx, mfy;

  ldpm_smul u_mul_xr (.clk_i, .en_i(adv), .a_i(x_dly_q[DLY_XY-1]), .b_i(rad_q), .p_o(xr));
  ldpm_smul u_mul_yr (.clk_i, .en_i(adv), .a_i(y_dly_q[DLY_XY-1]), .b_i(rad_q), .p_o(yr));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xd_q <= sadd(xr, tx_dly_q[DLY_T-1]);
      yd_q <= sadd(yr, ty_dly_q[DLY_T-1]);
    end
  end

  ldpm_smul u_mul_fx (.clk_i, .en_i(adv), .a_i(xd_q), .b_i(fx64), .p_o(mfx));
  ldpm_smul u_mul_fy (.clk_i, .en_i(adv), .a_i(yd_q), .b_i(fy64), .p_o(mfy));

  // Back to pixels and clamp to the signed 32-bit range.
  logic signed [64:0] sum_x, sum_y;
  logic signed [31:0] wx_d, wy_d, wx_q, wy_q;
  logic               clx, cly, clip_q;

  always_comb begin
    sum_x = $signed({mfx[63], mfx}) + $signed({{33{center_x_q[31]}}, center_x_q});
    sum_y = $signed({mfy[63], mfy}) + $signed({{33{center_y_q[31]}}, center_y_q});
    clx   = 1'b0;
    cly   = 1'b0;
    if (sum_x > OUT_MAX65) begin
      wx_d = OUT_MAX;
      clx  = 1'b1;
    end else if (sum_x < OUT_MIN65) begin
      wx_d = OUT_MIN;
      clx  = 1'b1;
    end else begin
      wx_d = sum_x[31:0];
    end
    if (sum_y > OUT_MAX65) begin
      wy_d = OUT_MAX;
      cly  = 1'b1;
    end else if (sum_y < OUT_MIN65) begin
      wy_d = OUT_MIN;
      cly  = 1'b1;
    end else begin
      wy_d = sum_y[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wx_q   <= wx_d;
      wy_q   <= wy_d;
      clip_q <= clx | cly;
    end
  end

  assign warped_o.valid    = valid_q[PIPE_LAT-1];
  assign warped_o.warped_x = wx_q;
  assign warped_o.warped_y = wy_q;
  assign warped_o.clipped  = clip_q;

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    warped_o.valid && !warped_o.ready |-> !point_i.ready)
    else $error("input accepted while the output is stalled");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_i.valid && point_i.ready |=> valid_q[0])
    else $error("accepted item did not enter the pipeline");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> valid_q == $past(valid_q))
    else $error("valid bits moved during a stall");

  a_clip_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    warped_o.valid && warped_o.clipped |->
      (warped_o.warped_x == OUT_MAX || warped_o.warped_x == OUT_MIN ||
       warped_o.warped_y == OUT_MAX || warped_o.warped_y == OUT_MIN))
    else $error("clipped set without a saturated coordinate");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_lens_distortion_point_map.sv =====
// Testbench of the lens distortion point map: random and directed points, scoreboard check.
module tb_lens_distortion_point_map;
  import ldpm_pkg::*;

  localparam int K3_CODE = 0;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               clipped;
  } warped_pt_t;

  class warp_scoreboard;
    logic [31:0] regs[8];
    warped_pt_t  pending_pts[$];
    int          errors;

    function new();
      regs = '{32'd65536000, 32'd65536000, 0, 0, 0, 0, 0, 0};
      errors = 0;
    endfunction

    function fix_t sat_sum(fix_t a, fix_t b);
      logic signed [64:0] s;
      s = $signed({a[63], a}) + $signed({b[63], b});
      if (!s[64] && s[63]) return SAT_MAX;
      if ((s[64] && !s[63]) || s[64:63] == 2'b11 && s[62:0] == '0) return -SAT_MAX;
      return s[63:0];
    endfunction

    function fix_t mul_q24(fix_t a, fix_t b);
      logic [63:0]  ma;
      logic [63:0]  mb;
      logic [127:0] p;
      fix_t         m;
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      p = {64'd0, ma} * {64'd0, mb};
      p = p + (128'd1 << 23);
      m = (|p[127:87]) ? SAT_MAX : fix_t'(p[87:24]);
      return (a[63] != b[63]) ? -m : m;
    endfunction

    function fix_t focal(logic [31:0] r);
      return (r == 0) ? 64'sd1 : fix_t'({32'd0, r});
    endfunction

    function fix_t ext(logic [31:0] v);
      return {{32{v[31]}}, v};
    endfunction

    function fix_t normalize(logic [31:0] p, logic [31:0] c, fix_t f);
      fix_t        d;
      logic [63:0] md;
      logic [63:0] q;
      d = ext(p) - ext(c);
      md = d[63] ? -d : d;
      q = ((md << 24) + (f >> 1)) / f;
      return d[63] ? -fix_t'(q) : fix_t'(q);
    endfunction

    function logic [31:0] to_pixel(fix_t v, fix_t f, logic [31:0] c, inout logic clip);
      fix_t pv;
      pv = sat_sum(mul_q24(v, f), ext(c));
      if (pv > 64'sh7FFF_FFFF) begin
        clip = 1'b1;
        return 32'h7FFF_FFFF;
      end
      if (pv < -64'sh8000_0000) begin
        clip = 1'b1;
        return 32'h8000_0000;
      end
      return pv[31:0];
    endfunction

    function void note_point(logic [31:0] px, logic [31:0] py);
      fix_t fx, fy, x, y, x2, y2, xy, xy2, r2, r4, r6, rad, tx, ty, xd, yd;
      fix_t k1, k2, k3, p1, p2;
      warped_pt_t e;
      logic clip;
      fx = focal(regs[REG_FOCAL_X]);
      fy = focal(regs[REG_FOCAL_Y]);
      k1 = ext(regs[REG_RADIAL_1]);
      k2 = ext(regs[REG_RADIAL_2]);
      k3 = ext(K3_CODE);
      p1 = ext(regs[REG_TANGENT_1]);
      p2 = ext(regs[REG_TANGENT_2]);
      x = normalize(px, regs[REG_CENTER_X], fx);
      y = normalize(py, regs[REG_CENTER_Y], fy);
      x2 = mul_q24(x, x);
      y2 = mul_q24(y, y);
      xy = mul_q24(x, y);
      xy2 = sat_sum(xy, xy);
      r2 = sat_sum(x2, y2);
      r4 = mul_q24(r2, r2);
      r6 = mul_q24(r4, r2);
      rad = sat_sum(sat_sum(sat_sum(ONE_Q24, mul_q24(k1, r2)), mul_q24(k2, r4)),
                    mul_q24(k3, r6));
      tx = sat_sum(mul_q24(p1, xy2), mul_q24(p2, sat_sum(r2, sat_sum(x2, x2))));
      ty = sat_sum(mul_q24(p1, sat_sum(r2, sat_sum(y2, y2))), mul_q24(p2, xy2));
      xd = sat_sum(mul_q24(x, rad), tx);
      yd = sat_sum(mul_q24(y, rad), ty);
      clip = 1'b0;
      e.x = to_pixel(xd, fx, regs[REG_CENTER_X], clip);
      e.y = to_pixel(yd, fy, regs[REG_CENTER_Y], clip);
      e.clipped = clip;
      pending_pts = {pending_pts, e};
    endfunction

    function void check_point(warped_pt_t got);
      warped_pt_t e;
      if (pending_pts.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected item: x=%h y=%h clipped=%b",
                                   got.x, got.y, got.clipped);
        return;
      end
      e = pending_pts.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10)
          $display("Item mismatch: expected x=%h y=%h clipped=%b, got x=%h y=%h clipped=%b",
                   e.x, e.y, e.clipped, got.x, got.y, got.clipped);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  int          send_idle;
  int          recv_idle;
  int          sent;
  warp_scoreboard sb;

  ldpm_in_if  pin();
  ldpm_out_if pout();

  lens_distortion_point_map #(.RADIAL_THIRD(K3_CODE)) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .point_i   (pin),
    .warped_o  (pout)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (pout.valid && pout.ready) begin
      sb.check_point('{pout.warped_x, pout.warped_y, pout.clipped});
    end
    pout.ready <= rst_ni && ($urandom_range(99) >= recv_idle);
  end

  task automatic send_point(logic [31:0] x, logic [31:0] y);
    if (sent < 550) begin
      send_idle = 10;
      recv_idle = 72;
    end else if (sent < 1100) begin
      send_idle = 72;
      recv_idle = 10;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    while ($urandom_range(99) < send_idle) begin
      pin.valid <= 1'b0;
      @(posedge clk_i);
    end
    pin.valid   <= 1'b1;
    pin.ideal_x <= x;
    pin.ideal_y <= y;
    @(posedge clk_i);
    while (!pin.ready) @(posedge clk_i);
    sb.note_point(x, y);
    sent++;
  endtask

  task automatic drain();
    pin.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_pts.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic load_setting(logic [31:0] v[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_idx_e'(i);
      cfg_data_i <= v[i];
      sb.regs[i] = v[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_point();
    if ($urandom_range(9) < 7) return $urandom_range(393216000) - 196608000;
    return $urandom;
  endfunction

  function automatic logic [31:0] rand_coef();
    return $urandom_range(33554432) - 16777216;
  endfunction

  task automatic random_points(int n);
    for (int i = 0; i < n; i++) send_point(rand_point(), rand_point());
  endtask

  logic [31:0] setting[8];
  logic [31:0] corner_pts[14][2];

  initial begin
    clk_i = 0;
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_idx_i = 0;
    cfg_data_i = 0;
    pin.valid = 0;
    pin.ideal_x = 0;
    pin.ideal_y = 0;
    pout.ready = 0;
    sent = 0;
    send_idle = 10;
    recv_idle = 72;
    sb = new();
    corner_pts = '{'{0, 0}, '{32'h7FFF_FFFF, 32'h7FFF_FFFF}, '{32'h8000_0000, 32'h8000_0000},
                   '{32'h7FFF_FFFF, 32'h8000_0000}, '{32'h8000_0000, 32'h7FFF_FFFF},
                   '{1, 32'hFFFF_FFFF}, '{32'hFFFF_FFFF, 1}, '{32'h0001_0000, 0},
                   '{0, 32'hFFFF_0000}, '{32'h03E8_0000, 32'h03E8_0000},
                   '{32'hFD80_0000, 32'h01E0_0000}, '{32'h7FFF_0000, 0},
                   '{32'h5555_5555, 32'hAAAA_AAAA}, '{32'hAAAA_AAAA, 32'h5555_5555}};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_pts[i]) send_point(corner_pts[i][0], corner_pts[i][1]);
    random_points(230);
    drain();

    setting = '{32'd800 << 16, 32'd820 << 16, 32'd640 << 16, 32'd360 << 16,
                -32'sd4697620, 32'sd1174405, 32'sd16777, -32'sd8389};
    load_setting(setting);
    foreach (corner_pts[i]) send_point(corner_pts[i][0], corner_pts[i][1]);
    random_points(190);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: setting = '{$urandom_range(4000, 100) << 16, $urandom_range(4000, 100) << 16,
                       rand_point(), rand_point(), rand_coef(), rand_coef(),
                       rand_coef(), rand_coef()};
        1: setting = '{0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'h8000_0000};
        2: setting = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        3: setting = '{1, 32'h0000_8000, 0, 0, $urandom, $urandom, $urandom, $urandom};
        4: setting = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom};
        default: setting = '{$urandom_range(2000, 300) << 16, $urandom_range(2000, 300) << 16,
                             rand_point(), rand_point(), rand_coef(), rand_coef(),
                             rand_coef(), rand_coef()};
      endcase
      load_setting(setting);
      random_points(200);
      drain();
    end

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
